@@ rtl/vqcp_pkg.sv @@
package vqcp_pkg;

   localparam int SLOT_BITS     = 15;
   localparam int LOG2_BITS     = 4;
   localparam int AVAIL_BITS    = 16;
   localparam int ADDR_BITS     = 64;
   localparam int LEN_BITS      = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [AVAIL_BITS-1:0] avail_type;

   // descriptor flag bits
   localparam int FLAG_NEXT  = 0;
   localparam int FLAG_WRITE = 1;

   typedef enum logic [1:0] {
      KIND_DESC   = 2'd0,
      KIND_AVAIL  = 2'd1,
      KIND_INDEX  = 2'd2,
      KIND_NOTIFY = 2'd3
   } kind_type;

   // everything one buffer needs to produce its results
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_BITS-1:0]  len;
      logic [1:0]           flags;
      slot_type             slot;
      slot_type             next_slot;
      logic                 last;
      logic                 notify;
      slot_type             avail_slot;
      slot_type             head;
      avail_type            avail_idx;
   } job_type;

   typedef struct packed {
      kind_type             kind;
      slot_type             slot;
      logic [ADDR_BITS-1:0] desc_addr;
      logic [LEN_BITS-1:0]  desc_len;
      logic [1:0]           desc_flags;
      slot_type             next_slot;
      avail_type            value;
      logic                 final_result;
   } result_type;

   // ring index mask; a log2 above SLOT_BITS saturates to the full slot width
   function automatic slot_type slot_mask(input logic [LOG2_BITS-1:0] lg);
      slot_type m;
      for (int i = 0; i < SLOT_BITS; i++) begin
         m[i] = (LOG2_BITS'(i) < lg);
      end
      return m;
   endfunction

endpackage

@@ rtl/vqcp_csr.sv @@
module vqcp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vqcp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [vqcp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [vqcp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output logic [vqcp_pkg::LOG2_BITS-1:0]      qsize_log2,
   output vqcp_pkg::avail_type                 queue_index
);
   import vqcp_pkg::*;

   localparam logic REG_QSIZE_LOG2  = 1'b0;
   localparam logic REG_QUEUE_INDEX = 1'b1;

   logic [LOG2_BITS-1:0] qsize_log2_ff;
   avail_type            queue_index_ff;
   logic                 reg_sel;
   logic                 wr_en;

   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         qsize_log2_ff  <= LOG2_BITS'(8);
         queue_index_ff <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            REG_QSIZE_LOG2:  qsize_log2_ff  <= csr_pwdata[LOG2_BITS-1:0];
            REG_QUEUE_INDEX: queue_index_ff <= csr_pwdata[AVAIL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_QSIZE_LOG2:
            csr_prdata = {{(CSR_DATA_BITS-LOG2_BITS){1'b0}}, qsize_log2_ff};
         REG_QUEUE_INDEX:
            csr_prdata = {{(CSR_DATA_BITS-AVAIL_BITS){1'b0}}, queue_index_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   assign qsize_log2  = qsize_log2_ff;
   assign queue_index = queue_index_ff;

endmodule

@@ rtl/vqcp_state.sv @@
module vqcp_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [vqcp_pkg::ADDR_BITS-1:0]      buffer_addr,
   input  logic [vqcp_pkg::LEN_BITS-1:0]       buffer_len,
   input  logic                                device_writes,
   input  logic                                chain_end,
   input  logic                                suppress_check,
   input  logic [vqcp_pkg::LOG2_BITS-1:0]      qsize_log2,
   output vqcp_pkg::job_type                   job
);
   import vqcp_pkg::*;

   slot_type  free_slot_ff, free_slot_in;
   slot_type  head_slot_ff, head_slot_in;
   logic      in_chain_ff,  in_chain_in;
   avail_type avail_count_ff, avail_count_in;

   slot_type  mask;
   slot_type  cur;
   slot_type  nxt;

   always_comb begin
      mask = slot_mask(qsize_log2);
      cur  = free_slot_ff & mask;
      nxt  = (cur + SLOT_BITS'(1)) & mask;

      // a new chain starts at the current free slot
      head_slot_in   = in_chain_ff ? head_slot_ff : cur;
      free_slot_in   = nxt;
      in_chain_in    = !chain_end;
      avail_count_in = chain_end ? avail_count_ff + AVAIL_BITS'(1) : avail_count_ff;

      job.addr              = buffer_addr;
      job.len               = buffer_len;
      job.flags[FLAG_NEXT]  = !chain_end;
      job.flags[FLAG_WRITE] = device_writes;
      job.slot              = cur;
      job.next_slot         = chain_end ? '0 : nxt;
      job.last              = chain_end;
      job.notify            = !suppress_check;
      job.avail_slot        = avail_count_ff[SLOT_BITS-1:0] & mask;
      job.head              = head_slot_in & mask;
      job.avail_idx         = avail_count_ff + AVAIL_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_slot_ff   <= '0;
         head_slot_ff   <= '0;
         in_chain_ff    <= 1'b0;
         avail_count_ff <= '0;
      end else if (accept) begin
         free_slot_ff   <= free_slot_in;
         head_slot_ff   <= head_slot_in;
         in_chain_ff    <= in_chain_in;
         avail_count_ff <= avail_count_in;
      end
   end

endmodule

@@ rtl/vqcp_emit.sv @@
module vqcp_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   in_ready,
   input  vqcp_pkg::job_type      job_in,
   input  vqcp_pkg::avail_type    queue_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vqcp_pkg::result_type   rsp
);
   import vqcp_pkg::*;

   logic       job_valid_ff;
   job_type    job_ff;
   kind_type   step_ff, step_in;
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   logic out_free;
   logic emit;
   logic fin;
   logic job_done;
   logic accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = job_valid_ff && out_free;
   assign job_done = emit && fin;
   assign in_ready = !job_valid_ff || job_done;
   assign accept   = req_valid && in_ready;

   always_comb begin
      rsp_in      = '0;
      rsp_in.kind = step_ff;
      fin         = 1'b1;
      step_in     = KIND_DESC;
      case (step_ff)
         KIND_DESC: begin
            rsp_in.slot       = job_ff.slot;
            rsp_in.desc_addr  = job_ff.addr;
            rsp_in.desc_len   = job_ff.len;
            rsp_in.desc_flags = job_ff.flags;
            rsp_in.next_slot  = job_ff.next_slot;
            fin               = !job_ff.last;
            step_in           = KIND_AVAIL;
         end
         KIND_AVAIL: begin
            rsp_in.slot  = job_ff.avail_slot;
            rsp_in.value = {{(AVAIL_BITS-SLOT_BITS){1'b0}}, job_ff.head};
            fin          = 1'b0;
            step_in      = KIND_INDEX;
         end
         KIND_INDEX: begin
            rsp_in.value = job_ff.avail_idx;
            fin          = !job_ff.notify;
            step_in      = KIND_NOTIFY;
         end
         KIND_NOTIFY: begin
            rsp_in.value = queue_index;
         end
         default: ;
      endcase
      rsp_in.final_result = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= KIND_DESC;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            job_valid_ff <= 1'b1;
            step_ff      <= KIND_DESC;
         end else if (job_done) begin
            job_valid_ff <= 1'b0;
         end else if (emit) begin
            step_ff <= step_in;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
      if (accept) begin
         job_ff <= job_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/virtqueue_chain_publisher.sv @@
// channel   direction  handshake                  payload
// req_      in         req_valid / req_stall      buffer addr, len, device-writes, chain-end,
//                                                 suppress check
// rsp_      out        rsp_valid / rsp_stall      kind, slot, descriptor fields, value, final
// csr_      in/out     APB psel/penable/pready    queue_size_log2 @0x0, queue_index @0x4
//
// One buffer is taken per cycle when it is not a chain end and rsp_stall is low; its
// descriptor write passes the job register, then the output register. A chain-end buffer
// yields three or four transactions; the job register sets throughput, issuing one result per
// unstalled cycle, so the next buffer waits until the last one issues. Reset is synchronous
// and clears ring state and valids; no clearing pass. A stalled result holds its value while
// the job register keeps the next buffer.
module virtqueue_chain_publisher (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [vqcp_pkg::ADDR_BITS-1:0]      req_buffer_addr,
   input  logic [vqcp_pkg::LEN_BITS-1:0]       req_buffer_len,
   input  logic                                req_device_writes,
   input  logic                                req_chain_end,
   input  logic                                req_suppress_check,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_kind,
   output logic [vqcp_pkg::SLOT_BITS-1:0]      rsp_slot,
   output logic [vqcp_pkg::ADDR_BITS-1:0]      rsp_desc_addr,
   output logic [vqcp_pkg::LEN_BITS-1:0]       rsp_desc_len,
   output logic [1:0]                          rsp_desc_flags,
   output logic [vqcp_pkg::SLOT_BITS-1:0]      rsp_next_slot,
   output logic [vqcp_pkg::AVAIL_BITS-1:0]     rsp_value,
   output logic                                rsp_final_result,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vqcp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [vqcp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [vqcp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import vqcp_pkg::*;

   logic [LOG2_BITS-1:0] qsize_log2;
   avail_type            queue_index;
   job_type              job;
   logic                 in_ready;
   logic                 accept;
   result_type           rsp;

   // a buffer transaction completes when the job register is free or drains now
   assign req_stall = !in_ready;
   assign accept    = req_valid && in_ready;

   vqcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .qsize_log2  (qsize_log2),
      .queue_index (queue_index)
   );

   // ring bookkeeping: free slot, chain head, avail count; updated at acceptance
   vqcp_state u_state (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .buffer_addr    (req_buffer_addr),
      .buffer_len     (req_buffer_len),
      .device_writes  (req_device_writes),
      .chain_end      (req_chain_end),
      .suppress_check (req_suppress_check),
      .qsize_log2     (qsize_log2),
      .job            (job)
   );

   // job register plus result sequencing into the output register
   vqcp_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .in_ready    (in_ready),
      .job_in      (job),
      .queue_index (queue_index),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_slot         = rsp.slot;
   assign rsp_desc_addr    = rsp.desc_addr;
   assign rsp_desc_len     = rsp.desc_len;
   assign rsp_desc_flags   = rsp.desc_flags;
   assign rsp_next_slot    = rsp.next_slot;
   assign rsp_value        = rsp.value;
   assign rsp_final_result = rsp.final_result;

endmodule

@@ rtl/vqcp_checker.sv @@
module vqcp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [1:0]                       rsp_kind,
   input logic [vqcp_pkg::ADDR_BITS-1:0]   rsp_desc_addr,
   input logic [1:0]                       rsp_desc_flags,
   input logic [vqcp_pkg::SLOT_BITS-1:0]   rsp_next_slot,
   input logic                             rsp_final_result
);
   import vqcp_pkg::*;

   // nothing leaves the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a descriptor without NEXT links to slot 0
   a_end_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DESC && !rsp_desc_flags[FLAG_NEXT]
         |-> rsp_next_slot == '0)
      else $error("chain-end descriptor has a nonzero link");

   // descriptor fields are zero on ring and notify transactions
   a_zero_desc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DESC
         |-> rsp_desc_addr == '0 && rsp_desc_flags == '0)
      else $error("descriptor fields set on a non-descriptor result");

   // notify always closes the buffer's results
   a_notify_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NOTIFY |-> rsp_final_result)
      else $error("notify not marked final");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result dropped or changed");

endmodule

bind virtqueue_chain_publisher vqcp_checker u_vqcp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_desc_addr    (rsp_desc_addr),
   .rsp_desc_flags   (rsp_desc_flags),
   .rsp_next_slot    (rsp_next_slot),
   .rsp_final_result (rsp_final_result)
);

@@ tb/sv/vqcp_tb_pkg.sv @@
package vqcp_tb_pkg;

   import vqcp_pkg::*;

   typedef enum int {
      REG_QUEUE_SIZE_LOG2 = 0,
      REG_QUEUE_INDEX     = 1
   } csr_reg_type;

   // Tracks ring state and predicts descriptor / avail / notify transactions.
   class chain_scoreboard;
      logic [LOG2_BITS-1:0] size_log2;
      avail_type            queue_number;
      slot_type             free_slot;
      slot_type             head_slot;
      bit                   in_chain;
      avail_type            avail_count;
      result_type           pending[$];
      int unsigned          fail_count;
      int unsigned          buffer_count;
      int unsigned          chain_count;
      int unsigned          result_count;

      function new();
         size_log2    = LOG2_BITS'(8);
         queue_number = '0;
         free_slot    = '0;
         head_slot    = '0;
         in_chain     = 1'b0;
         avail_count  = '0;
         fail_count   = 0;
         buffer_count = 0;
         chain_count  = 0;
         result_count = 0;
      endfunction

      function void set_register(csr_reg_type which, logic [31:0] data);
         case (which)
            REG_QUEUE_SIZE_LOG2: size_log2 = data[LOG2_BITS-1:0];
            REG_QUEUE_INDEX:     queue_number = data[AVAIL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(csr_reg_type which);
         if (which == REG_QUEUE_SIZE_LOG2) begin
            return 32'(size_log2);
         end
         return 32'(queue_number);
      endfunction

      // log2 saturates at the slot width
      function slot_type ring_mask();
         int unsigned lg;
         lg = (size_log2 > SLOT_BITS) ? SLOT_BITS : int'(size_log2);
         return slot_type'((32'd1 << lg) - 32'd1);
      endfunction

      function void note_buffer(logic [ADDR_BITS-1:0] addr, logic [LEN_BITS-1:0] len,
                                logic dev_wr, logic last, logic suppress);
         slot_type   mask;
         slot_type   cur;
         slot_type   nxt;
         result_type r;
         mask = ring_mask();
         cur  = free_slot & mask;
         nxt  = (cur + 1'b1) & mask;
         buffer_count++;
         if (!in_chain) begin
            head_slot = cur;
         end
         r                       = '0;
         r.kind                  = KIND_DESC;
         r.slot                  = cur;
         r.desc_addr             = addr;
         r.desc_len              = len;
         r.desc_flags[FLAG_NEXT] = ~last;
         r.desc_flags[FLAG_WRITE] = dev_wr;
         r.next_slot             = last ? slot_type'(0) : nxt;
         r.final_result          = ~last;
         pending.push_back(r);
         free_slot = nxt;
         if (!last) begin
            in_chain = 1'b1;
            return;
         end
         // publish: avail ring entry, new avail index, then optional notify
         chain_count++;
         r        = '0;
         r.kind   = KIND_AVAIL;
         r.slot   = slot_type'(avail_count) & mask;
         r.value  = avail_type'(head_slot & mask);
         pending.push_back(r);
         avail_count = avail_count + 1'b1;
         r              = '0;
         r.kind         = KIND_INDEX;
         r.value        = avail_count;
         r.final_result = suppress;
         pending.push_back(r);
         if (!suppress) begin
            r              = '0;
            r.kind         = KIND_NOTIFY;
            r.value        = queue_number;
            r.final_result = 1'b1;
            pending.push_back(r);
         end
         in_chain = 1'b0;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            $error("unexpected transaction: kind %0d slot %0d value 0x%0h",
                   got.kind, got.slot, got.value);
            fail_count++;
            return;
         end
         want = pending.pop_front();
         result_count++;
         compare_field("kind", 64'(want.kind), 64'(got.kind));
         compare_field("slot", 64'(want.slot), 64'(got.slot));
         compare_field("desc_addr", want.desc_addr, got.desc_addr);
         compare_field("desc_len", 64'(want.desc_len), 64'(got.desc_len));
         compare_field("desc_flags", 64'(want.desc_flags), 64'(got.desc_flags));
         compare_field("next_slot", 64'(want.next_slot), 64'(got.next_slot));
         compare_field("value", 64'(want.value), 64'(got.value));
         compare_field("final_result", 64'(want.final_result), 64'(got.final_result));
      endfunction
   endclass

endpackage

@@ tb/sv/tb_virtqueue_chain_publisher.sv @@
module tb_virtqueue_chain_publisher;

   import vqcp_pkg::*;
   import vqcp_tb_pkg::*;

   // cycles with no transaction on either channel before the run is declared hung;
   // worst legit quiet stretch is a stall burst or a drain plus two CSR accesses
   localparam int WATCHDOG_LIMIT = 600;
   localparam int PHASE_BUFFERS  = 39;
   localparam int RANDOM_PHASES  = 8;

   logic                     clock = 1'b0;
   logic                     reset;

   logic                     req_valid;
   logic                     req_stall;
   logic [ADDR_BITS-1:0]     req_buffer_addr;
   logic [LEN_BITS-1:0]      req_buffer_len;
   logic                     req_device_writes;
   logic                     req_chain_end;
   logic                     req_suppress_check;

   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_kind;
   logic [SLOT_BITS-1:0]     rsp_slot;
   logic [ADDR_BITS-1:0]     rsp_desc_addr;
   logic [LEN_BITS-1:0]      rsp_desc_len;
   logic [1:0]               rsp_desc_flags;
   logic [SLOT_BITS-1:0]     rsp_next_slot;
   logic [AVAIL_BITS-1:0]    rsp_value;
   logic                     rsp_final_result;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   chain_scoreboard sb;
   bit              idle_on;       // random gaps and stalls enabled
   int unsigned     stall_left;
   int unsigned     quiet_cycles;
   int unsigned     setting_count;

   virtqueue_chain_publisher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_buffer_addr    (req_buffer_addr),
      .req_buffer_len     (req_buffer_len),
      .req_device_writes  (req_device_writes),
      .req_chain_end      (req_chain_end),
      .req_suppress_check (req_suppress_check),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_slot           (rsp_slot),
      .rsp_desc_addr      (rsp_desc_addr),
      .rsp_desc_len       (rsp_desc_len),
      .rsp_desc_flags     (rsp_desc_flags),
      .rsp_next_slot      (rsp_next_slot),
      .rsp_value          (rsp_value),
      .rsp_final_result   (rsp_final_result),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: stall in bursts while idling is enabled.
   // Stall changes at the falling edge, like every other TB-driven input.
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_stall  = 1'b1;
            stall_left = stall_left - 1;
         end else begin
            rsp_stall = 1'b0;
            if (idle_on && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 14);
            end
         end
      end
   end

   // Output monitor: every accepted result transaction goes to the scoreboard.
   always @(posedge clock) begin : result_monitor
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind         = kind_type'(rsp_kind);
         seen.slot         = rsp_slot;
         seen.desc_addr    = rsp_desc_addr;
         seen.desc_len     = rsp_desc_len;
         seen.desc_flags   = rsp_desc_flags;
         seen.next_slot    = rsp_next_slot;
         seen.value        = rsp_value;
         seen.final_result = rsp_final_result;
         sb.check_result(seen);
      end
   end

   // Watchdog: counts consecutive cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.pending.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // One buffer transaction. An optional gap goes in front;
   // valid stays high across back-to-back buffers.
   task automatic send_buffer(logic [ADDR_BITS-1:0] addr, logic [LEN_BITS-1:0] len,
                              logic dev_wr, logic last, logic suppress);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_buffer_addr    = addr;
      req_buffer_len     = len;
      req_device_writes  = dev_wr;
      req_chain_end      = last;
      req_suppress_check = suppress;
      do @(posedge clock); while (req_stall);
      sb.note_buffer(addr, len, dev_wr, last, suppress);
   endtask

   function automatic logic [ADDR_BITS-1:0] pick_addr();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] pick_len();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // A chain of buffers with random content; close=0 leaves it open so the
   // next phase continues it (possibly under a new ring size).
   task automatic send_chain(int unsigned count, bit close);
      for (int unsigned i = 0; i < count; i++) begin
         send_buffer(pick_addr(), pick_len(), 1'($urandom), close && (i == count - 1),
                     1'($urandom));
      end
   endtask

   task automatic csr_write(csr_reg_type which, logic [31:0] data);
      logic [31:0] want;
      // setup + access, write lands at the edge with penable/pready high
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_BITS'(4 * int'(which));
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(which, data);
      // read back the same register
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      want = sb.register_value(which);
      if (csr_prdata !== want) begin
         $error("csr readback at 0x%0h: expected 0x%0h, got 0x%0h", csr_paddr, want,
                csr_prdata);
         sb.fail_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Registers change only with the block idle: input quiet and every expected
   // transaction delivered.
   task automatic reconfigure(logic [LOG2_BITS-1:0] lg, logic [15:0] qnum);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_QUEUE_SIZE_LOG2, 32'(lg));
      csr_write(REG_QUEUE_INDEX, 32'(qnum));
      setting_count++;
   endtask

   initial begin
      sb                 = new();
      idle_on            = 1'b1;
      setting_count      = 0;
      quiet_cycles       = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_buffer_addr    = '0;
      req_buffer_len     = '0;
      req_device_writes  = 1'b0;
      req_chain_end      = 1'b0;
      req_suppress_check = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // reset config (256-entry ring, queue 0): field extremes, notify vs suppressed
      send_buffer('1, '1, 1'b1, 1'b1, 1'b0);
      send_buffer('0, '0, 1'b0, 1'b1, 1'b1);
      // three-buffer chain, mixed WRITE flags
      send_buffer(pick_addr(), pick_len(), 1'b1, 1'b0, 1'b0);
      send_buffer(pick_addr(), pick_len(), 1'b0, 1'b0, 1'b1);
      send_buffer(pick_addr(), pick_len(), 1'b1, 1'b1, 1'b0);

      // single-entry ring: all slots and links collapse to 0; chain outgrows ring
      reconfigure(LOG2_BITS'(0), 16'hFFFF);
      send_buffer(pick_addr(), pick_len(), 1'b0, 1'b0, 1'b1);
      send_buffer(pick_addr(), pick_len(), 1'b1, 1'b0, 1'b0);
      send_buffer(pick_addr(), pick_len(), 1'b0, 1'b1, 1'b0);
      send_buffer(pick_addr(), pick_len(), 1'b1, 1'b1, 1'b1);

      // 4-entry ring: 6-buffer chain wraps, then a chain left open
      reconfigure(LOG2_BITS'(2), 16'h5A3C);
      send_chain(6, 1'b1);
      send_chain(2, 1'b0);

      // ring shrinks in the middle of that chain; stored slots get re-masked
      reconfigure(LOG2_BITS'(1), 16'h0001);
      send_buffer(pick_addr(), pick_len(), 1'b1, 1'b1, 1'b0);

      // full-width ring
      reconfigure(LOG2_BITS'(SLOT_BITS), 16'h8001);
      send_buffer(pick_addr(), pick_len(), 1'b0, 1'b1, 1'b0);
      send_buffer(pick_addr(), pick_len(), 1'b1, 1'b1, 1'b1);

      // --- random phases; the last one runs with no gaps or stalls ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         int unsigned          sent;
         int unsigned          count;
         logic [LOG2_BITS-1:0] lg;
         logic [15:0]          qnum;
         case ($urandom_range(0, 5))
            0:       lg = LOG2_BITS'(0);
            1:       lg = LOG2_BITS'(SLOT_BITS);
            2:       lg = LOG2_BITS'(1);
            default: lg = LOG2_BITS'($urandom_range(0, 15));
         endcase
         case ($urandom_range(0, 3))
            0:       qnum = 16'h0000;
            1:       qnum = 16'hFFFF;
            default: qnum = 16'($urandom);
         endcase
         reconfigure(lg, qnum);
         if (phase == RANDOM_PHASES - 1) begin
            idle_on = 1'b0;
         end
         sent = 0;
         while (sent < PHASE_BUFFERS) begin
            // mostly short chains, now and then one long enough to lap a small ring
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
            if (count > PHASE_BUFFERS - sent) begin
               count = PHASE_BUFFERS - sent;
            end
            // the phase's final chain is sometimes left open across the reconfigure
            send_chain(count, (sent + count < PHASE_BUFFERS) || ($urandom_range(0, 3) != 0));
            sent += count;
         end
      end
      // close any chain still open so it publishes
      send_chain(1, 1'b1);

      // --- drain ---
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d transactions from %0d buffers, %0d chains published",
               sb.result_count, sb.buffer_count, sb.chain_count);
      $display("across %0d ring/queue settings, incl. 1-entry, full-width and mid-chain resize",
               setting_count);
      if (sb.fail_count == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
